### src/assert_macros.svh
// Assertion macros used by the receiver core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property on clk, switched off while rst_n is low.
`define FCR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define FCR_ASSERT_IMPLY(lbl, ante, cons, msg) \
  `FCR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

### src/fcr_pkg.sv
// Types, codes and constants of the framed command receiver.
package fcr_pkg;

  localparam int MAX_LENGTH_DEF = 64;

  localparam logic [7:0] SYNC_RESET   = 8'hAA;
  localparam logic [7:0] STATUS_RESET = 8'h10;
  localparam logic [7:0] LAMP_RESET   = 8'h20;

  localparam logic [15:0] SHORT_LIMIT = 16'd4;
  localparam int          HEAD_DEPTH  = 5;

  // parser phases
  localparam logic [2:0] PH_SYNC   = 3'd0;
  localparam logic [2:0] PH_CMD    = 3'd1;
  localparam logic [2:0] PH_LEN_HI = 3'd2;
  localparam logic [2:0] PH_LEN_LO = 3'd3;
  localparam logic [2:0] PH_DATA   = 3'd4;
  localparam logic [2:0] PH_SUM    = 3'd5;

  // event codes
  localparam logic [2:0] EV_STATUS  = 3'd0;
  localparam logic [2:0] EV_LAMP    = 3'd1;
  localparam logic [2:0] EV_UNKNOWN = 3'd2;
  localparam logic [2:0] EV_BADSUM  = 3'd3;
  localparam logic [2:0] EV_SHORT   = 3'd4;
  localparam logic [2:0] EV_REPLAY  = 3'd5;

  // register indexes
  localparam logic [1:0] REG_SYNC   = 2'd0;
  localparam logic [1:0] REG_STATUS = 2'd1;
  localparam logic [1:0] REG_LAMP   = 2'd2;

  typedef struct packed {
    logic [7:0] sync_value;
    logic [7:0] status_command;
    logic [7:0] lamp_command;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  event_code;
    logic [7:0]  command_code;
    logic        lamp_on;
    logic [31:0] packets_seen;
    logic [31:0] checksum_failures;
    logic [31:0] replays_rejected;
    logic [31:0] link_bytes_echo;
  } result_t;

endpackage

### src/fcr_cfg_regs.sv
// APB configuration registers: sync value and the two command codes.
module fcr_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output fcr_pkg::cfg_t       cfg
);

  fcr_pkg::cfg_t cfg_r;
  fcr_pkg::cfg_t cfg_nxt;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        fcr_pkg::REG_SYNC:   cfg_nxt.sync_value     = pwdata[7:0];
        fcr_pkg::REG_STATUS: cfg_nxt.status_command = pwdata[7:0];
        fcr_pkg::REG_LAMP:   cfg_nxt.lamp_command   = pwdata[7:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      fcr_pkg::REG_SYNC:   prdata = {24'd0, cfg_r.sync_value};
      fcr_pkg::REG_STATUS: prdata = {24'd0, cfg_r.status_command};
      fcr_pkg::REG_LAMP:   prdata = {24'd0, cfg_r.lamp_command};
      default:             prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_value     <= fcr_pkg::SYNC_RESET;
      cfg_r.status_command <= fcr_pkg::STATUS_RESET;
      cfg_r.lamp_command   <= fcr_pkg::LAMP_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/fcr_parser.sv
// Packet framing state, checksum, replay check and command decode.
module fcr_parser #(
  parameter int MAX_LENGTH = fcr_pkg::MAX_LENGTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        rx_byte,
  input  logic [31:0]       side_link_bytes,
  input  fcr_pkg::cfg_t     cfg,
  output logic              res_valid,
  output fcr_pkg::result_t  res
);

  localparam int PW = $clog2(MAX_LENGTH + 1);

  logic [2:0]    phase_r, phase_nxt;
  logic [7:0]    cmd_r, cmd_nxt;
  logic [15:0]   len_r, len_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0]    sum_r, sum_nxt;
  logic [7:0]    head_r   [fcr_pkg::HEAD_DEPTH];
  logic [7:0]    head_nxt [fcr_pkg::HEAD_DEPTH];
  logic [31:0]   last_seq_r, last_seq_nxt;
  logic [31:0]   pkt_cnt_r, pkt_cnt_nxt;
  logic [31:0]   fail_cnt_r, fail_cnt_nxt;
  logic [31:0]   replay_cnt_r, replay_cnt_nxt;
  logic          lamp_r, lamp_nxt;

  logic [15:0]   len_full;
  logic [PW-1:0] pos_inc;
  logic [31:0]   seq;
  logic [2:0]    ev;
  logic [31:0]   echo;

  assign len_full = {len_r[15:8], rx_byte};
  assign pos_inc  = pos_r + PW'(1);
  assign seq      = {head_r[0], head_r[1], head_r[2], head_r[3]};

  always_comb begin
    phase_nxt      = phase_r;
    cmd_nxt        = cmd_r;
    len_nxt        = len_r;
    pos_nxt        = pos_r;
    sum_nxt        = sum_r;
    head_nxt       = head_r;
    last_seq_nxt   = last_seq_r;
    pkt_cnt_nxt    = pkt_cnt_r;
    fail_cnt_nxt   = fail_cnt_r;
    replay_cnt_nxt = replay_cnt_r;
    lamp_nxt       = lamp_r;
    res_valid      = 1'b0;
    ev             = fcr_pkg::EV_UNKNOWN;
    echo           = 32'd0;
    if (step) begin
      case (phase_r)
        fcr_pkg::PH_SYNC: begin
          if (rx_byte == cfg.sync_value) phase_nxt = fcr_pkg::PH_CMD;
        end
        fcr_pkg::PH_CMD: begin
          cmd_nxt   = rx_byte;
          phase_nxt = fcr_pkg::PH_LEN_HI;
        end
        fcr_pkg::PH_LEN_HI: begin
          len_nxt   = {rx_byte, 8'd0};
          phase_nxt = fcr_pkg::PH_LEN_LO;
        end
        fcr_pkg::PH_LEN_LO: begin
          len_nxt = len_full;
          pos_nxt = '0;
          sum_nxt = 8'd0;
          // oversize length drops the packet without a trace
          if (len_full > 16'(MAX_LENGTH)) phase_nxt = fcr_pkg::PH_SYNC;
          else if (len_full == 16'd0)     phase_nxt = fcr_pkg::PH_SUM;
          else                            phase_nxt = fcr_pkg::PH_DATA;
        end
        fcr_pkg::PH_DATA: begin
          if (pos_r < PW'(fcr_pkg::HEAD_DEPTH)) head_nxt[pos_r[2:0]] = rx_byte;
          pos_nxt = pos_inc;
          sum_nxt = sum_r + rx_byte;
          if (16'(pos_inc) >= len_r) phase_nxt = fcr_pkg::PH_SUM;
        end
        fcr_pkg::PH_SUM: begin
          phase_nxt   = fcr_pkg::PH_SYNC;
          res_valid   = 1'b1;
          pkt_cnt_nxt = pkt_cnt_r + 32'd1;
          if (rx_byte != sum_r) begin
            fail_cnt_nxt = fail_cnt_r + 32'd1;
            ev           = fcr_pkg::EV_BADSUM;
          end else if (len_r < fcr_pkg::SHORT_LIMIT) begin
            ev = fcr_pkg::EV_SHORT;
          end else if (seq <= last_seq_r) begin
            replay_cnt_nxt = replay_cnt_r + 32'd1;
            ev             = fcr_pkg::EV_REPLAY;
          end else begin
            last_seq_nxt = seq;
            if (cmd_r == cfg.status_command) begin
              ev   = fcr_pkg::EV_STATUS;
              echo = side_link_bytes;
            end else if (cmd_r == cfg.lamp_command) begin
              // length four leaves head byte 4 from an earlier packet
              lamp_nxt = (head_r[4] != 8'd0);
              ev       = fcr_pkg::EV_LAMP;
            end else begin
              ev = fcr_pkg::EV_UNKNOWN;
            end
          end
        end
        default: phase_nxt = fcr_pkg::PH_SYNC;
      endcase
    end
  end

  always_comb begin
    res.event_code        = ev;
    res.command_code      = cmd_r;
    res.lamp_on           = lamp_nxt;
    res.packets_seen      = pkt_cnt_nxt;
    res.checksum_failures = fail_cnt_nxt;
    res.replays_rejected  = replay_cnt_nxt;
    res.link_bytes_echo   = echo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= fcr_pkg::PH_SYNC;
      cmd_r        <= 8'd0;
      len_r        <= 16'd0;
      pos_r        <= '0;
      sum_r        <= 8'd0;
      for (int i = 0; i < fcr_pkg::HEAD_DEPTH; i++) head_r[i] <= 8'd0;
      last_seq_r   <= 32'd0;
      pkt_cnt_r    <= 32'd0;
      fail_cnt_r   <= 32'd0;
      replay_cnt_r <= 32'd0;
      lamp_r       <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      cmd_r        <= cmd_nxt;
      len_r        <= len_nxt;
      pos_r        <= pos_nxt;
      sum_r        <= sum_nxt;
      head_r       <= head_nxt;
      last_seq_r   <= last_seq_nxt;
      pkt_cnt_r    <= pkt_cnt_nxt;
      fail_cnt_r   <= fail_cnt_nxt;
      replay_cnt_r <= replay_cnt_nxt;
      lamp_r       <= lamp_nxt;
    end
  end

endmodule

### src/framed_command_receiver_core.sv
// Top level of the framed command receiver: input register, parser, result register.
// Takes one received byte per cycle while not stalled. A byte is held in the input
// register, then the parser updates its framing state; on the checksum byte the result
// is registered in the output register. The input keeps taking a byte every cycle as
// long as the result register is empty or being emptied; it stalls only while a result
// waits and out_ready is low. Bytes outside a packet, and packets with a length above
// MAX_LENGTH, give no result. Configuration registers (sync value at 0x0, status
// command at 0x4, lamp command at 0x8) are to be written over the APB port only while
// the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module framed_command_receiver_core #(
  parameter int MAX_LENGTH = fcr_pkg::MAX_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic [31:0] in_side_link_bytes,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_code,
  output logic [7:0]  out_command_code,
  output logic        out_lamp_on,
  output logic [31:0] out_packets_seen,
  output logic [31:0] out_checksum_failures,
  output logic [31:0] out_replays_rejected,
  output logic [31:0] out_link_bytes_echo,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  fcr_pkg::cfg_t    cfg;
  fcr_pkg::result_t res;
  fcr_pkg::result_t res_r;
  logic             res_valid;

  logic        in_v_r, in_v_nxt;
  logic [7:0]  byte_r;
  logic [31:0] side_r;
  logic        out_v_r, out_v_nxt;
  logic        advance;
  logic        step;

  assign advance  = !out_v_r || out_ready;
  assign step     = in_v_r && advance;
  assign in_ready = !in_v_r || advance;

  always_comb begin
    in_v_nxt  = in_ready ? in_valid : in_v_r;
    out_v_nxt = advance ? res_valid : out_v_r;
  end

  fcr_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fcr_parser #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .step            (step),
    .rx_byte         (byte_r),
    .side_link_bytes (side_r),
    .cfg             (cfg),
    .res_valid       (res_valid),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r <= in_rx_byte;
      side_r <= in_side_link_bytes;
    end
    if (step && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid             = out_v_r;
  assign out_event_code        = res_r.event_code;
  assign out_command_code      = res_r.command_code;
  assign out_lamp_on           = res_r.lamp_on;
  assign out_packets_seen      = res_r.packets_seen;
  assign out_checksum_failures = res_r.checksum_failures;
  assign out_replays_rejected  = res_r.replays_rejected;
  assign out_link_bytes_echo   = res_r.link_bytes_echo;

  `FCR_ASSERT_IMPLY(a_stall_only_when_full, !in_ready, out_v_r && !out_ready, "input stalled without a waiting result")
  `FCR_ASSERT_IMPLY(a_event_in_range, out_v_r, out_event_code <= fcr_pkg::EV_REPLAY, "event code out of range")
  `FCR_ASSERT_IMPLY(a_echo_only_status, out_v_r && (out_event_code != fcr_pkg::EV_STATUS), out_link_bytes_echo == 32'd0, "link echo on a non-status event")
  `FCR_ASSERT_IMPLY(a_result_from_step, res_valid, step, "parser result without a byte step")

endmodule

### dv/tb_top.sv
// Testbench for the framed command receiver: packet stream stimulus, parser prediction and result checks.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN       = fcr_pkg::MAX_LENGTH_DEF;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    logic [7:0]  rx;
    logic [31:0] side;
  } rx_item_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic [31:0] in_side_link_bytes = 32'h0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_code;
  logic [7:0]  out_command_code;
  logic        out_lamp_on;
  logic [31:0] out_packets_seen;
  logic [31:0] out_checksum_failures;
  logic [31:0] out_replays_rejected;
  logic [31:0] out_link_bytes_echo;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = 4'h0;
  logic [31:0] pwdata = 32'h0;
  logic [31:0] prdata;
  logic        pready;

  framed_command_receiver_core #(.MAX_LENGTH(MAX_LEN)) u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_rx_byte            (in_rx_byte),
    .in_side_link_bytes    (in_side_link_bytes),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_event_code        (out_event_code),
    .out_command_code      (out_command_code),
    .out_lamp_on           (out_lamp_on),
    .out_packets_seen      (out_packets_seen),
    .out_checksum_failures (out_checksum_failures),
    .out_replays_rejected  (out_replays_rejected),
    .out_link_bytes_echo   (out_link_bytes_echo),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  // stimulus and expectation stores
  rx_item_t         bytes_to_send[$];
  fcr_pkg::result_t events_due[$];
  rx_item_t         next_item;
  fcr_pkg::result_t due_event;
  int               mismatches = 0;
  int               send_gap = 0;
  int               ready_gap = 0;
  int               hold_left = 0;
  logic             hold_request = 1'b0;
  logic             idle_on = 1'b1;
  logic [31:0]      seq_hint = 32'h0;

  // parser mirror
  fcr_pkg::cfg_t mirror_cfg = '{fcr_pkg::SYNC_RESET, fcr_pkg::STATUS_RESET,
                                fcr_pkg::LAMP_RESET};
  logic [2:0]  ph = fcr_pkg::PH_SYNC;
  logic [7:0]  pkt_cmd = 8'h00;
  logic [15:0] pay_len = 16'h0;
  int          pay_pos = 0;
  logic [7:0]  run_sum = 8'h00;
  logic [7:0]  head [fcr_pkg::HEAD_DEPTH] = '{default: 8'h00};
  logic [31:0] last_seq = 32'h0;
  logic [31:0] pkt_count = 32'h0;
  logic [31:0] fail_count = 32'h0;
  logic [31:0] replay_count = 32'h0;
  logic        lamp = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Advance the parser mirror by one received byte; queue an event on the checksum byte.
  task automatic parse_byte(input logic [7:0] b, input logic [31:0] side);
    fcr_pkg::result_t r;
    logic [31:0]      seq;
    r = '0;
    case (ph)
      fcr_pkg::PH_SYNC: begin
        if (b == mirror_cfg.sync_value) ph = fcr_pkg::PH_CMD;
      end
      fcr_pkg::PH_CMD: begin
        pkt_cmd = b;
        ph = fcr_pkg::PH_LEN_HI;
      end
      fcr_pkg::PH_LEN_HI: begin
        pay_len = {b, 8'h00};
        ph = fcr_pkg::PH_LEN_LO;
      end
      fcr_pkg::PH_LEN_LO: begin
        pay_len[7:0] = b;
        pay_pos = 0;
        run_sum = 8'h00;
        if (pay_len > MAX_LEN) ph = fcr_pkg::PH_SYNC;
        else if (pay_len == 16'h0) ph = fcr_pkg::PH_SUM;
        else ph = fcr_pkg::PH_DATA;
      end
      fcr_pkg::PH_DATA: begin
        if (pay_pos < fcr_pkg::HEAD_DEPTH) head[pay_pos[2:0]] = b;
        pay_pos++;
        run_sum = run_sum + b;
        if (pay_pos >= pay_len) ph = fcr_pkg::PH_SUM;
      end
      fcr_pkg::PH_SUM: begin
        ph = fcr_pkg::PH_SYNC;
        pkt_count++;
        if (b != run_sum) begin
          fail_count++;
          r.event_code = fcr_pkg::EV_BADSUM;
        end else if (pay_len < fcr_pkg::SHORT_LIMIT) begin
          r.event_code = fcr_pkg::EV_SHORT;
        end else begin
          seq = {head[0], head[1], head[2], head[3]};
          if (seq <= last_seq) begin
            replay_count++;
            r.event_code = fcr_pkg::EV_REPLAY;
          end else begin
            last_seq = seq;
            if (pkt_cmd == mirror_cfg.status_command) begin
              r.event_code = fcr_pkg::EV_STATUS;
              r.link_bytes_echo = side;
            end else if (pkt_cmd == mirror_cfg.lamp_command) begin
              lamp = (head[4] != 8'h00);
              r.event_code = fcr_pkg::EV_LAMP;
            end else begin
              r.event_code = fcr_pkg::EV_UNKNOWN;
            end
          end
        end
        r.command_code      = pkt_cmd;
        r.lamp_on           = lamp;
        r.packets_seen      = pkt_count;
        r.checksum_failures = fail_count;
        r.replays_rejected  = replay_count;
        events_due.push_back(r);
      end
      default: ph = fcr_pkg::PH_SYNC;
    endcase
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_byte(in_rx_byte, in_side_link_bytes);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (bytes_to_send.size() != 0) begin
          next_item = bytes_to_send.pop_front();
          in_valid <= 1'b1;
          in_rx_byte <= next_item.rx;
          in_side_link_bytes <= next_item.side;
          if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 10);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure; the long hold is counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        ready_gap = $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (events_due.size() == 0) begin
        $display("%0t: result transfer with nothing expected, event %0d", $time,
                 out_event_code);
        mismatches++;
      end else begin
        due_event = events_due.pop_front();
        check_field("event_code", 32'(due_event.event_code), 32'(out_event_code));
        check_field("command_code", 32'(due_event.command_code), 32'(out_command_code));
        check_field("lamp_on", 32'(due_event.lamp_on), 32'(out_lamp_on));
        check_field("packets_seen", due_event.packets_seen, out_packets_seen);
        check_field("checksum_failures", due_event.checksum_failures, out_checksum_failures);
        check_field("replays_rejected", due_event.replays_rejected, out_replays_rejected);
        check_field("link_bytes_echo", due_event.link_bytes_echo, out_link_bytes_echo);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || psel) quiet = 0;
      else quiet++;
    end
    $display("framed_command_receiver_core test failed");
    $finish;
  end

  task automatic put_byte(input logic [7:0] b);
    rx_item_t item;
    item.rx = b;
    case ($urandom_range(0, 15))
      0:       item.side = 32'h0;
      1:       item.side = 32'hFFFF_FFFF;
      default: item.side = $urandom;
    endcase
    bytes_to_send.push_back(item);
  endtask

  // random bytes that never look like a sync byte
  task automatic put_noise(input int n);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      do b = 8'($urandom_range(0, 255)); while (b == mirror_cfg.sync_value);
      put_byte(b);
    end
  endtask

  task automatic put_header(input logic [7:0] cmd, input logic [15:0] len);
    put_byte(mirror_cfg.sync_value);
    put_byte(cmd);
    put_byte(len[15:8]);
    put_byte(len[7:0]);
  endtask

  // Whole packet: header, sequence number big-endian first, lamp byte fifth, filler, checksum.
  task automatic put_packet(input logic [7:0] cmd, input int len, input logic [31:0] seq,
                            input logic [7:0] lamp_byte, input logic [7:0] sum_err);
    logic [7:0] b;
    logic [7:0] sum;
    sum = 8'h00;
    put_header(cmd, len[15:0]);
    for (int i = 0; i < len; i++) begin
      if (i < 4) b = seq[31 - 8*i -: 8];
      else if (i == 4) b = lamp_byte;
      else b = 8'($urandom_range(0, 255));
      sum = sum + b;
      put_byte(b);
    end
    put_byte(sum ^ sum_err);
  endtask

  task automatic put_random_packet();
    logic [7:0]  cmd;
    logic [7:0]  lamp_byte;
    logic [31:0] seq;
    int          len;
    int          pick;
    int          back;
    pick = $urandom_range(0, 99);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: cmd = mirror_cfg.status_command;
      4, 5, 6:    cmd = mirror_cfg.lamp_command;
      default:    cmd = 8'($urandom_range(0, 255));
    endcase
    len = ($urandom_range(0, 6) == 0) ? $urandom_range(13, MAX_LEN) : $urandom_range(4, 12);
    lamp_byte = $urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(1, 255));
    if (pick < 60) begin
      if ($urandom_range(0, 9) == 0) seq = seq_hint + $urandom_range(1, 1 << 24);
      else seq = seq_hint + $urandom_range(1, 1 << 16);
      seq_hint = seq;
      put_packet(cmd, len, seq, lamp_byte, 8'h00);
    end else if (pick < 68) begin
      back = (seq_hint < 1000) ? seq_hint : 1000;
      put_packet(cmd, len, seq_hint - $urandom_range(0, back), lamp_byte, 8'h00);
    end else if (pick < 76) begin
      put_packet(cmd, len, seq_hint + 1, lamp_byte, 8'($urandom_range(1, 255)));
    end else if (pick < 82) begin
      put_packet(cmd, $urandom_range(0, 3), $urandom, lamp_byte,
                 ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
    end else if (pick < 88) begin
      if ($urandom_range(0, 1)) put_header(cmd, 16'($urandom_range(MAX_LEN + 1, MAX_LEN + 8)));
      else put_header(cmd, 16'($urandom_range(MAX_LEN + 1, 16'hFFFF)));
    end else if (pick < 94) begin
      put_noise($urandom_range(1, 6));
    end else begin
      // packet cut short; filler runs it out to a checksum so framing recovers
      len = $urandom_range(2, 12);
      put_header(cmd, len[15:0]);
      put_noise(len + 1 + $urandom_range(0, 3));
    end
  endtask

  task automatic run_phase(input int budget);
    while (bytes_to_send.size() < budget) put_random_packet();
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (bytes_to_send.size() != 0 || in_valid || events_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    logic [31:0] word;
    word = $urandom;
    word[7:0] = val;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      fcr_pkg::REG_SYNC:   mirror_cfg.sync_value = val;
      fcr_pkg::REG_STATUS: mirror_cfg.status_command = val;
      fcr_pkg::REG_LAMP:   mirror_cfg.lamp_command = val;
      default:    ;
    endcase
  endtask

  task automatic set_config(input logic [7:0] sync_b, input logic [7:0] status_b,
                            input logic [7:0] lamp_b);
    write_reg(fcr_pkg::REG_SYNC, sync_b);
    write_reg(fcr_pkg::REG_STATUS, status_b);
    write_reg(fcr_pkg::REG_LAMP, lamp_b);
  endtask

  initial begin
    logic [7:0] shared_code;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings
    put_byte(8'h00);
    put_byte(8'hFF);
    put_packet(fcr_pkg::STATUS_RESET, 0, 32'h0, 8'h00, 8'h00);        // empty payload, good sum
    put_packet(8'h55, 0, 32'h0, 8'h00, 8'hFF);                        // empty payload, bad sum
    put_packet(fcr_pkg::LAMP_RESET, 3, 32'hFFFF_FF00, 8'h00, 8'h00);  // too short
    put_packet(fcr_pkg::STATUS_RESET, 4, 32'h0, 8'h00, 8'h00);        // sequence 0 is stale
    put_packet(fcr_pkg::STATUS_RESET, 5, 32'h1, 8'h00, 8'h00);
    put_packet(fcr_pkg::LAMP_RESET, 5, 32'h2, 8'hFF, 8'h00);          // lamp on
    put_packet(fcr_pkg::LAMP_RESET, 4, 32'h3, 8'h00, 8'h00);          // lamp byte left over
    put_packet(8'h7E, 6, 32'h4, 8'h00, 8'h00);                        // unknown command
    put_packet(fcr_pkg::STATUS_RESET, 5, 32'h4, 8'h00, 8'h00);        // replay
    put_packet(fcr_pkg::STATUS_RESET, 5, 32'h5, 8'h00, 8'h01);        // bad sum
    put_header(fcr_pkg::LAMP_RESET, 16'(MAX_LEN + 1));                // dropped
    put_header(fcr_pkg::STATUS_RESET, 16'hFFFF);                      // dropped
    put_packet(fcr_pkg::LAMP_RESET, MAX_LEN, 32'h5, 8'h00, 8'h00);    // longest, lamp off
    seq_hint = 32'h5;
    wait_drained();

    set_config(8'h00, 8'hFF, 8'h00);
    run_phase(350);
    wait_drained();

    // long receiver hold while the sender keeps offering bytes
    set_config(8'hFF, 8'h00, 8'hFF);
    hold_request = 1'b1;
    run_phase(350);
    wait_drained();

    shared_code = 8'($urandom_range(0, 255));
    set_config(shared_code, shared_code, shared_code);
    run_phase(300);
    wait_drained();

    set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    run_phase(350);
    wait_drained();

    // last stretch at full rate on both sides
    set_config(fcr_pkg::SYNC_RESET, fcr_pkg::STATUS_RESET, fcr_pkg::LAMP_RESET);
    idle_on = 1'b0;
    run_phase(350);
    put_packet(fcr_pkg::STATUS_RESET, 5, 32'hFFFF_FFFF, 8'h00, 8'h00);
    put_packet(fcr_pkg::LAMP_RESET, 5, 32'hFFFF_FFFF, 8'h01, 8'h00);
    wait_drained();

    if (mismatches == 0) begin
      $display("framed_command_receiver_core test passed");
    end else begin
      $display("framed_command_receiver_core test failed");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/fcr_pkg.sv
src/fcr_cfg_regs.sv
src/fcr_parser.sv
src/framed_command_receiver_core.sv
dv/tb_top.sv
